[src/colormap_pixel_shader_top_assert.svh]
// Assertion macros used by the shader controller.
`ifndef COLORMAP_PIXEL_SHADER_TOP_ASSERT_SVH
`define COLORMAP_PIXEL_SHADER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CPS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("shader assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CPS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("shader assertion failed");

`endif

[src/cps_pkg.sv]
package cps_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_MAP_DEPTH  = 256;

    // Field widths.
    localparam int MODE_W   = 2;
    localparam int COORD_W  = 8;
    localparam int PIX_W    = 32;
    localparam int CHAN_W   = 16;
    localparam int PLOT_W   = 9;
    localparam int CFG_SIZE_W = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Arithmetic widths: span and offset, product, dividend, quotient and ratio.
    localparam int SPAN_W = PIX_W + 1;
    localparam int PROD_W = CFG_SIZE_W + SPAN_W;
    localparam int NUM_W  = PROD_W + CHAN_W;
    localparam int QUO_W  = CFG_SIZE_W + CHAN_W;
    localparam int RATIO_W = CHAN_W + 1;

    // Input tdata layout.
    localparam int S_IDX_LSB = 0;
    localparam int S_X_LSB   = S_IDX_LSB + COORD_W;
    localparam int S_Y_LSB   = S_X_LSB + COORD_W;
    localparam int S_PIX_LSB = S_Y_LSB + COORD_W;
    localparam int S_R_LSB   = S_PIX_LSB + PIX_W;
    localparam int S_G_LSB   = S_R_LSB + CHAN_W;
    localparam int S_B_LSB   = S_G_LSB + CHAN_W;
    localparam int S_DATA_W  = 104;

    // Output tdata layout.
    localparam int M_PX_LSB = 0;
    localparam int M_PY_LSB = M_PX_LSB + PLOT_W;
    localparam int M_R_LSB  = M_PY_LSB + PLOT_W;
    localparam int M_G_LSB  = M_R_LSB + CHAN_W;
    localparam int M_B_LSB  = M_G_LSB + CHAN_W;
    localparam int M_DATA_W = 72;

    typedef enum logic [MODE_W-1:0] {
        MODE_MAP  = 2'd0,
        MODE_PIX  = 2'd1,
        MODE_READ = 2'd2
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 3'd0,
        CFG_HEIGHT = 3'd1,
        CFG_MAP    = 3'd2,
        CFG_LOWER  = 3'd3,
        CFG_UPPER  = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic clear;
        logic wr_map;
        logic wr_pix;
        logic load_item;
        logic scan_start;
        logic scan;
        logic range;
        logic mul;
        logic div;
        logic post;
        logic map_next;
        logic blend;
        logic out_load;
    } cps_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic stale;
        logic scan_done;
        logic div_done;
        logic out_free;
    } cps_status_t;

endpackage

[src/colormap_pixel_shader_top.sv]
// Colormap pixel shader. Items arrive on the s_ stream; s_tuser carries the mode.
// Mode 0 writes a colormap entry, mode 1 writes a pixel, and mode 2 reads a pixel
// and returns one colored result on the m_ stream. Modes 0 and 1 and the unused
// mode 3 produce no result. Registers are written on the cfg_ channel, which is
// always ready; write them only while the block is idle.
// After reset the pixel store is cleared one entry per cycle, all MAX_WIDTH *
// MAX_HEIGHT entries (65536 by default); s_tready stays low until that ends.
// A read goes through a pixel fetch, a range check, a multiply, a bit-serial
// divide that yields one quotient bit per cycle, two colormap reads and a blend
// before m_tvalid. If pixels or the image size changed since the last read, a
// min/max scan of the used area runs first, one pixel per cycle through the
// single read port of the store.
// The block works on one item at a time. The result sits in an output register;
// while the receiver stalls, further writes are still accepted, and a read
// finishes its work and then waits for the output register to drain.
module colormap_pixel_shader_top #(
    parameter int MAX_WIDTH  = cps_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cps_pkg::DEF_MAX_HEIGHT,
    parameter int MAP_DEPTH  = cps_pkg::DEF_MAP_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // map_index[7:0], column_x[15:8], row_y[23:16], pixel_value[55:24],
    // map_red[71:56], map_green[87:72], map_blue[103:88]
    input  logic [cps_pkg::S_DATA_W-1:0]   s_tdata,
    // mode[1:0]
    input  logic [cps_pkg::MODE_W-1:0]     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // plot_x[8:0], plot_y[17:9], red[33:18], green[49:34], blue[65:50], zero fill
    output logic [cps_pkg::M_DATA_W-1:0]   m_tdata,
    // out_of_range[0]
    output logic [0:0]                     m_tuser,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cps_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cps_pkg::*;

    cps_cmd_t    cmd;
    cps_status_t status;

    // The controller sequences clear, scan, divide, map reads and blend.
    cps_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds both stores, the registers and the arithmetic.
    cps_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAP_DEPTH  (MAP_DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

[src/cps_ctrl.sv]
`include "colormap_pixel_shader_top_assert.svh"

module cps_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [cps_pkg::MODE_W-1:0]  s_tuser,
    input  cps_pkg::cps_status_t        status,
    output cps_pkg::cps_cmd_t           cmd
);
    import cps_pkg::*;

    typedef enum logic [10:0] {
        S_CLEAR = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_SCAN  = 11'b00000000100,
        S_PIXRD = 11'b00000001000,
        S_RANGE = 11'b00000010000,
        S_MUL   = 11'b00000100000,
        S_DIV   = 11'b00001000000,
        S_POST  = 11'b00010000000,
        S_MAPK  = 11'b00100000000,
        S_MAPK1 = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic   blend_reg, blend_next;

    always_comb begin
        state_next = state_reg;
        blend_next = 1'b0;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clear = 1'b1;
                if (status.clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    unique case (mode_t'(s_tuser))
                        MODE_MAP: cmd.wr_map = 1'b1;
                        MODE_PIX: cmd.wr_pix = 1'b1;
                        MODE_READ: begin
                            cmd.load_item = 1'b1;
                            if (status.stale) begin
                                cmd.scan_start = 1'b1;
                                state_next = S_SCAN;
                            end else begin
                                state_next = S_PIXRD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (status.scan_done) begin
                    state_next = S_PIXRD;
                end
            end
            S_PIXRD: state_next = S_RANGE;
            S_RANGE: begin
                cmd.range = 1'b1;
                state_next = S_MUL;
            end
            S_MUL: begin
                cmd.mul = 1'b1;
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.div = 1'b1;
                if (status.div_done) begin
                    state_next = S_POST;
                end
            end
            S_POST: begin
                cmd.post = 1'b1;
                state_next = S_MAPK;
            end
            S_MAPK: state_next = S_MAPK1;
            S_MAPK1: begin
                cmd.map_next = 1'b1;
                blend_next = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                // The first cycle here forms the channel products.
                cmd.blend = blend_reg;
                if (!blend_reg && status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            blend_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            blend_reg <= blend_next;
        end
    end

    `CPS_ASSERT_IMP(a_load_needs_free, aclk, aresetn, cmd.out_load, status.out_free)
    `CPS_ASSERT_NXT(a_scan_clears_stale, aclk, aresetn, state_reg == S_SCAN && status.scan_done, !status.stale)
    `CPS_ASSERT_NXT(a_div_holds, aclk, aresetn, state_reg == S_DIV && !status.div_done, state_reg == S_DIV)

endmodule

[src/cps_datapath.sv]
module cps_datapath #(
    parameter int MAX_WIDTH  = cps_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cps_pkg::DEF_MAX_HEIGHT,
    parameter int MAP_DEPTH  = cps_pkg::DEF_MAP_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [cps_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cps_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [cps_pkg::M_DATA_W-1:0]   m_tdata,
    output logic [0:0]                     m_tuser,
    input  cps_pkg::cps_cmd_t              cmd,
    output cps_pkg::cps_status_t           status
);
    import cps_pkg::*;

    localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int MW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int CW = $clog2(QUO_W);
    localparam int WidthReset  = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
    localparam int HeightReset = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;
    localparam int MapReset    = (MAP_DEPTH < 256) ? MAP_DEPTH : 256;

    // Configuration registers; the sizes saturate on write, the bounds are kept as given.
    logic [CFG_SIZE_W-1:0]  width_reg, height_reg, map_reg;
    logic signed [PIX_W-1:0] lower_reg, upper_reg;
    logic [CFG_SIZE_W-1:0]  cfg_v;
    logic                   cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid;
    assign cfg_v     = cfg_data[CFG_SIZE_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= CFG_SIZE_W'(WidthReset);
            height_reg <= CFG_SIZE_W'(HeightReset);
            map_reg    <= CFG_SIZE_W'(MapReset);
            lower_reg  <= '0;
            upper_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_WIDTH: begin
                    if (cfg_v == '0) width_reg <= CFG_SIZE_W'(1);
                    else if (16'(cfg_v) > 16'(MAX_WIDTH)) width_reg <= CFG_SIZE_W'(MAX_WIDTH);
                    else width_reg <= cfg_v;
                end
                CFG_HEIGHT: begin
                    if (cfg_v == '0) height_reg <= CFG_SIZE_W'(1);
                    else if (16'(cfg_v) > 16'(MAX_HEIGHT)) height_reg <= CFG_SIZE_W'(MAX_HEIGHT);
                    else height_reg <= cfg_v;
                end
                CFG_MAP: begin
                    if (cfg_v < CFG_SIZE_W'(2)) map_reg <= CFG_SIZE_W'(2);
                    else if (16'(cfg_v) > 16'(MAP_DEPTH)) map_reg <= CFG_SIZE_W'(MAP_DEPTH);
                    else map_reg <= cfg_v;
                end
                CFG_LOWER: lower_reg <= cfg_data;
                CFG_UPPER: upper_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input fields.
    logic [COORD_W-1:0] in_idx, in_x, in_y;
    logic [PIX_W-1:0]   in_pix;
    logic               in_inside;
    logic [AW-1:0]      in_addr;

    assign in_idx = s_tdata[S_IDX_LSB +: COORD_W];
    assign in_x   = s_tdata[S_X_LSB +: COORD_W];
    assign in_y   = s_tdata[S_Y_LSB +: COORD_W];
    assign in_pix = s_tdata[S_PIX_LSB +: PIX_W];
    assign in_inside = (16'(in_x) < 16'(MAX_WIDTH)) && (16'(in_y) < 16'(MAX_HEIGHT));
    assign in_addr = AW'(AW'(YW'(in_y)) * AW'(MAX_WIDTH) + AW'(XW'(in_x)));

    // Item registers for a read.
    logic [COORD_W-1:0] x_reg, y_reg;
    logic               inside_reg;
    logic [AW-1:0]      pix_addr_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            x_reg        <= in_x;
            y_reg        <= in_y;
            inside_reg   <= in_inside;
            pix_addr_reg <= in_addr;
        end
    end

    // Scan and clear control.
    logic [XW-1:0] sx_reg;
    logic [YW-1:0] sy_reg;
    logic          issue_reg, scan_rd_reg, first_reg, stale_reg;
    logic [AW-1:0] clr_addr_reg, scan_addr, raddr, waddr;
    logic signed [PIX_W-1:0] dmin_reg, dmax_reg, rd_data_reg, wdata;
    logic          we, scan_done, sx_last, sy_last;

    assign scan_addr = AW'(AW'(sy_reg) * AW'(MAX_WIDTH) + AW'(sx_reg));
    assign sx_last   = 16'(sx_reg) == 16'(width_reg) - 16'd1;
    assign sy_last   = 16'(sy_reg) == 16'(height_reg) - 16'd1;
    assign scan_done = !issue_reg && !scan_rd_reg;
    assign raddr     = issue_reg ? scan_addr : pix_addr_reg;
    assign we        = cmd.clear || (cmd.wr_pix && in_inside);
    assign waddr     = cmd.clear ? clr_addr_reg : in_addr;
    assign wdata     = cmd.clear ? '0 : in_pix;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_reg    <= 1'b0;
            scan_rd_reg  <= 1'b0;
            first_reg    <= 1'b0;
            stale_reg    <= 1'b1;
            clr_addr_reg <= '0;
            dmin_reg     <= '0;
            dmax_reg     <= '0;
            sx_reg       <= '0;
            sy_reg       <= '0;
        end else begin
            if (cmd.clear) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.scan_start) begin
                issue_reg <= 1'b1;
                first_reg <= 1'b1;
                sx_reg    <= '0;
                sy_reg    <= '0;
            end else if (cmd.scan && issue_reg) begin
                if (sx_last) begin
                    sx_reg <= '0;
                    if (sy_last) issue_reg <= 1'b0;
                    else sy_reg <= sy_reg + 1'b1;
                end else begin
                    sx_reg <= sx_reg + 1'b1;
                end
            end
            scan_rd_reg <= cmd.scan && issue_reg;
            if (scan_rd_reg) begin
                first_reg <= 1'b0;
                if (first_reg || rd_data_reg < dmin_reg) dmin_reg <= rd_data_reg;
                if (first_reg || rd_data_reg > dmax_reg) dmax_reg <= rd_data_reg;
            end
            if (cfg_we && (cfg_idx_t'(cfg_index) == CFG_WIDTH ||
                           cfg_idx_t'(cfg_index) == CFG_HEIGHT)) begin
                stale_reg <= 1'b1;
            end else if (cmd.wr_pix && in_inside) begin
                stale_reg <= 1'b1;
            end else if (cmd.scan && scan_done) begin
                stale_reg <= 1'b0;
            end
        end
    end

    // Pixel store.
    logic [PIX_W-1:0] pix_mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            pix_mem[waddr] <= wdata;
        end
        rd_data_reg <= pix_mem[raddr];
    end

    // Range check and span.
    logic signed [PIX_W-1:0] lo, hi, value;
    logic [SPAN_W-1:0] span_reg, d_reg;
    logic              inr_reg, zero_span_reg;
    logic [SPAN_W-1:0] span_c;

    assign lo     = (lower_reg < dmin_reg) ? lower_reg : dmin_reg;
    assign hi     = (upper_reg > dmax_reg) ? upper_reg : dmax_reg;
    assign value  = inside_reg ? rd_data_reg : '0;
    assign span_c = {hi[PIX_W-1], hi} - {lo[PIX_W-1], lo};

    always_ff @(posedge aclk) begin
        if (cmd.range) begin
            span_reg      <= span_c;
            d_reg         <= {value[PIX_W-1], value} - {lo[PIX_W-1], lo};
            inr_reg       <= (lo <= value) && (value <= hi);
            zero_span_reg <= span_c == '0;
        end
    end

    // Restoring division of n1*d*65536 by span, one quotient bit a cycle.
    logic [CFG_SIZE_W-1:0] n1;
    logic [PROD_W-1:0]     prod;
    logic [NUM_W-1:0]      num;
    logic [SPAN_W-1:0]     rem_reg;
    logic [QUO_W-1:0]      low_reg, q_reg;
    logic [CW-1:0]         cnt_reg;
    logic [SPAN_W:0]       trial, diff;
    logic                  ge;

    assign n1    = map_reg - 1'b1;
    assign prod  = PROD_W'(n1) * PROD_W'(d_reg);
    assign num   = {prod, {CHAN_W{1'b0}}};
    assign trial = {rem_reg, low_reg[QUO_W-1]};
    assign diff  = trial - {1'b0, span_reg};
    assign ge    = trial >= {1'b0, span_reg};

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            rem_reg <= num[NUM_W-1:QUO_W];
            low_reg <= num[QUO_W-1:0];
            q_reg   <= '0;
            cnt_reg <= '0;
        end else if (cmd.div) begin
            rem_reg <= ge ? SPAN_W'(diff) : SPAN_W'(trial);
            low_reg <= {low_reg[QUO_W-2:0], 1'b0};
            q_reg   <= {q_reg[QUO_W-2:0], ge};
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // Segment and ratio, clamped to the last segment; a zero span gives the first.
    logic [CFG_SIZE_W-1:0] k_raw;
    logic [MW-1:0]         k_reg;
    logic [RATIO_W-1:0]    ratio_reg;

    assign k_raw = q_reg[QUO_W-1:CHAN_W];

    always_ff @(posedge aclk) begin
        if (cmd.post) begin
            if (zero_span_reg) begin
                k_reg     <= '0;
                ratio_reg <= '0;
            end else if (k_raw >= n1) begin
                k_reg     <= MW'(n1 - 1'b1);
                ratio_reg <= RATIO_W'(1) << CHAN_W;
            end else begin
                k_reg     <= MW'(k_raw);
                ratio_reg <= {1'b0, q_reg[CHAN_W-1:0]};
            end
        end
    end

    // Colormap store, entries held as {blue, green, red}.
    logic [3*CHAN_W-1:0] map_mem [MAP_DEPTH];
    logic [3*CHAN_W-1:0] map_rd_reg, ca_reg;
    logic [MW-1:0]       map_raddr;

    assign map_raddr = cmd.map_next ? MW'({1'b0, k_reg} + 1'b1) : k_reg;

    always_ff @(posedge aclk) begin
        if (cmd.wr_map && (16'(in_idx) < 16'(MAP_DEPTH))) begin
            map_mem[MW'(in_idx)] <= s_tdata[S_R_LSB +: 3*CHAN_W];
        end
        map_rd_reg <= map_mem[map_raddr];
        if (cmd.map_next) begin
            ca_reg <= map_rd_reg;
        end
    end

    // Blend products, then rounded sums.
    logic [CHAN_W+RATIO_W-1:0] pa_reg [3];
    logic [CHAN_W+RATIO_W-1:0] pb_reg [3];
    logic [CHAN_W+RATIO_W:0]   sum [3];
    logic [RATIO_W-1:0]        inv_ratio;

    assign inv_ratio = (RATIO_W'(1) << CHAN_W) - ratio_reg;

    always_ff @(posedge aclk) begin
        if (cmd.blend) begin
            for (int c = 0; c < 3; c++) begin
                pa_reg[c] <= (CHAN_W+RATIO_W)'(ca_reg[c*CHAN_W +: CHAN_W]) *
                             (CHAN_W+RATIO_W)'(inv_ratio);
                pb_reg[c] <= (CHAN_W+RATIO_W)'(map_rd_reg[c*CHAN_W +: CHAN_W]) *
                             (CHAN_W+RATIO_W)'(ratio_reg);
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            sum[c] = {1'b0, pa_reg[c]} + {1'b0, pb_reg[c]} +
                     (CHAN_W+RATIO_W+1)'(1 << (CHAN_W - 1));
        end
    end

    // Output register.
    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic                m_oor_reg;
    logic [3*CHAN_W-1:0] color;

    always_comb begin
        if (inr_reg) begin
            color = {sum[2][CHAN_W +: CHAN_W], sum[1][CHAN_W +: CHAN_W],
                     sum[0][CHAN_W +: CHAN_W]};
        end else begin
            color = {{2*CHAN_W{1'b0}}, {CHAN_W{1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= {{(M_DATA_W - M_B_LSB - CHAN_W){1'b0}}, color,
                            PLOT_W'(y_reg) + 1'b1, PLOT_W'(x_reg) + 1'b1};
            m_oor_reg   <= !inr_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_oor_reg;

    assign status.clear_last = clr_addr_reg == AW'(Depth - 1);
    assign status.stale      = stale_reg;
    assign status.scan_done  = scan_done;
    assign status.div_done   = cnt_reg == CW'(QUO_W - 1);
    assign status.out_free   = !m_tvalid_reg || m_tready;

endmodule

[bench/colormap_pixel_shader_top_tb.sv]
`default_nettype none

module colormap_pixel_shader_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cps_pkg::*;

    // The spare mode code has no enum member; it must produce no result.
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    // Cycles to let an item that makes no result finish before a register write.
    localparam int SETTLE_CYCLES = 60;

    typedef struct {
        logic [PLOT_W-1:0] px;
        logic [PLOT_W-1:0] py;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              oor;
    } shade_t;

    // Shadow of the shader: pixel store, colormap, scan results and registers.
    // Each accepted read pushes the color it must produce; results pop in order.
    class shade_scoreboard;
        int                pix[65536];
        logic [CHAN_W-1:0] cmap[256][3];
        longint            data_min;
        longint            data_max;
        bit                stale;
        int unsigned       width;
        int unsigned       height;
        int unsigned       entries;
        longint            lo_req;
        longint            hi_req;
        shade_t            colors_due[$];
        int                errors;

        function new();
            foreach (pix[i]) pix[i] = 0;
            foreach (cmap[i, j]) cmap[i][j] = '0;
            data_min = 0;
            data_max = 0;
            stale = 1;
            width = 256;
            height = 256;
            entries = 256;
            lo_req = 0;
            hi_req = 0;
            errors = 0;
        endfunction

        function int pending();
            return colors_due.size();
        endfunction

        task report(string msg);
            $display("ERROR at %0t: %s", $time, msg);
            errors++;
        endtask

        function int unsigned clip(logic [CFG_DATA_W-1:0] data, int unsigned lo,
                                   int unsigned hi);
            int unsigned v;
            v = data[CFG_SIZE_W-1:0];
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_WIDTH: begin
                    width = clip(data, 1, 256);
                    stale = 1;
                end
                CFG_HEIGHT: begin
                    height = clip(data, 1, 256);
                    stale = 1;
                end
                CFG_MAP:   entries = clip(data, 2, 256);
                CFG_LOWER: lo_req = longint'(signed'(data));
                CFG_UPPER: hi_req = longint'(signed'(data));
                default: ;
            endcase
        endfunction

        function void scan_used_area();
            data_min = pix[0];
            data_max = pix[0];
            for (int y = 0; y < height; y++) begin
                for (int x = 0; x < width; x++) begin
                    if (pix[y*256+x] < data_min) data_min = pix[y*256+x];
                    if (pix[y*256+x] > data_max) data_max = pix[y*256+x];
                end
            end
            stale = 0;
        endfunction

        function logic [CHAN_W-1:0] mix(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b,
                                         longint unsigned ratio);
            longint unsigned s;
            s = a * (65536 - ratio) + b * ratio + 32768;
            return s[31:16];
        endfunction

        function void note_item(logic [MODE_W-1:0] mode, logic [S_DATA_W-1:0] d);
            int x;
            int y;
            longint lo;
            longint hi;
            longint value;
            longint unsigned span;
            longint unsigned off;
            longint unsigned n1;
            longint unsigned seg;
            longint unsigned ratio;
            shade_t c;
            x = d[S_X_LSB +: COORD_W];
            y = d[S_Y_LSB +: COORD_W];
            case (mode)
                MODE_MAP: begin
                    cmap[d[S_IDX_LSB +: COORD_W]][0] = d[S_R_LSB +: CHAN_W];
                    cmap[d[S_IDX_LSB +: COORD_W]][1] = d[S_G_LSB +: CHAN_W];
                    cmap[d[S_IDX_LSB +: COORD_W]][2] = d[S_B_LSB +: CHAN_W];
                end
                MODE_PIX: begin
                    pix[y*256+x] = signed'(d[S_PIX_LSB +: PIX_W]);
                    stale = 1;
                end
                MODE_READ: begin
                    if (stale) scan_used_area();
                    lo = (lo_req < data_min) ? lo_req : data_min;
                    hi = (hi_req > data_max) ? hi_req : data_max;
                    value = pix[y*256+x];
                    c.px = PLOT_W'(x + 1);
                    c.py = PLOT_W'(y + 1);
                    c.red = 16'hFFFF;
                    c.green = '0;
                    c.blue = '0;
                    c.oor = 1;
                    if (lo <= value && value <= hi) begin
                        span = hi - lo;
                        off = value - lo;
                        n1 = entries - 1;
                        seg = 0;
                        ratio = 0;
                        // A zero span stays on the first segment at its start.
                        if (span != 0) begin
                            seg = (n1 * off) / span;
                            if (seg > n1 - 1) seg = n1 - 1;
                            ratio = ((n1 * off - seg * span) << 16) / span;
                        end
                        c.red = mix(cmap[seg][0], cmap[seg+1][0], ratio);
                        c.green = mix(cmap[seg][1], cmap[seg+1][1], ratio);
                        c.blue = mix(cmap[seg][2], cmap[seg+1][2], ratio);
                        c.oor = 0;
                    end
                    colors_due.push_back(c);
                end
                default: ;
            endcase
        endfunction

        task check_result(logic [M_DATA_W-1:0] d, logic oor);
            shade_t c;
            if (colors_due.size() == 0) begin
                report("result transfer with no read outstanding");
            end else begin
                c = colors_due.pop_front();
                if (d[M_PX_LSB +: PLOT_W] !== c.px)
                    report($sformatf("plot_x %0d, want %0d", d[M_PX_LSB +: PLOT_W], c.px));
                if (d[M_PY_LSB +: PLOT_W] !== c.py)
                    report($sformatf("plot_y %0d, want %0d", d[M_PY_LSB +: PLOT_W], c.py));
                if (d[M_R_LSB +: CHAN_W] !== c.red)
                    report($sformatf("red %h, want %h", d[M_R_LSB +: CHAN_W], c.red));
                if (d[M_G_LSB +: CHAN_W] !== c.green)
                    report($sformatf("green %h, want %h", d[M_G_LSB +: CHAN_W], c.green));
                if (d[M_B_LSB +: CHAN_W] !== c.blue)
                    report($sformatf("blue %h, want %h", d[M_B_LSB +: CHAN_W], c.blue));
                if (oor !== c.oor)
                    report($sformatf("out_of_range %b, want %b", oor, c.oor));
            end
        endtask
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic [MODE_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [0:0]            m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    shade_scoreboard sb = new();
    int  items_accepted = 0;
    // Set by the back-pressure process to hold off the receiver completely.
    bit  rx_hold = 0;

    colormap_pixel_shader_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // All transfers are observed at the rising edge. The shadow model is updated
    // here, in handshake order, so register writes and items never get reordered.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.write_reg(cfg_idx_t'(cfg_index), cfg_data);
            if (s_tvalid && s_tready) begin
                sb.note_item(s_tuser, s_tdata);
                items_accepted++;
            end
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser[0]);
        end
    end

    // Sends one item and holds it until the block takes it, then leaves a gap
    // that is usually short or absent and now and then long.
    task send_item(logic [MODE_W-1:0] mode, logic [7:0] idx, logic [7:0] x,
                   logic [7:0] y, logic [31:0] value, logic [15:0] red,
                   logic [15:0] green, logic [15:0] blue);
        int n;
        int gap;
        s_tvalid = 1'b1;
        s_tuser = mode;
        s_tdata = '0;
        s_tdata[S_IDX_LSB +: COORD_W] = idx;
        s_tdata[S_X_LSB +: COORD_W] = x;
        s_tdata[S_Y_LSB +: COORD_W] = y;
        s_tdata[S_PIX_LSB +: PIX_W] = value;
        s_tdata[S_R_LSB +: CHAN_W] = red;
        s_tdata[S_G_LSB +: CHAN_W] = green;
        s_tdata[S_B_LSB +: CHAN_W] = blue;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        n = $urandom_range(0, 99);
        gap = (n < 65) ? 0 : (n < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    task cfg_write(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Registers may change only once every read has returned and any trailing
    // write has had time to finish inside the block.
    task wait_idle();
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task set_regs(logic [31:0] w, logic [31:0] h, logic [31:0] m, logic [31:0] lo,
                  logic [31:0] hi);
        cfg_write(CFG_WIDTH, w);
        cfg_write(CFG_HEIGHT, h);
        cfg_write(CFG_MAP, m);
        cfg_write(CFG_LOWER, lo);
        cfg_write(CFG_UPPER, hi);
    endtask

    function logic [31:0] pick_value();
        int n;
        n = $urandom_range(0, 9);
        case (n)
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2, 3, 4: return ($urandom_range(0, 4000) - 2000) << 8;
            default: return $urandom;
        endcase
    endfunction

    function logic [31:0] pick_bound();
        int n;
        n = $urandom_range(0, 3);
        case (n)
            0: return 32'h0;
            1: return ($urandom_range(0, 4000) - 2000) << 8;
            default: return $urandom;
        endcase
    endfunction

    // Receiver: mostly ready, with short stalls, occasional long ones, and a
    // complete hold-off whenever the back-pressure process asks for it.
    initial begin
        int stall_left;
        int n;
        stall_left = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold) begin
                m_tready = 1'b0;
            end else if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else begin
                m_tready = 1'b1;
                n = $urandom_range(0, 99);
                if (n < 15) stall_left = $urandom_range(1, 3);
                else if (n < 18) stall_left = $urandom_range(15, 50);
            end
        end
    end

    // Long hold-off in the middle of the random traffic so that a finished read
    // waits in the output register and the input side stalls behind it.
    initial begin
        wait (items_accepted >= 600);
        rx_hold = 1'b1;
        repeat (500) @(posedge aclk);
        rx_hold = 1'b0;
    end

    initial begin
        #50_000_000;
        $display("colormap_pixel_shader_top: mismatch");
        $finish;
    end

    initial begin
        int n;
        int x;
        int y;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_WIDTH;
        cfg_data = '0;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        // Fill the whole colormap first so that no read can touch an entry that
        // was never written. The first and last entries take the channel extremes.
        for (int i = 0; i < 256; i++) begin
            if (i == 0) send_item(MODE_MAP, i, 0, 0, 0, 16'h0, 16'h0, 16'h0);
            else if (i == 255) send_item(MODE_MAP, i, 0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            else send_item(MODE_MAP, i, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom);
        end

        // Directed part at the reset sizes. The first read sees an all-zero store
        // with zero bounds, so the span is empty and the color is entry zero.
        send_item(MODE_READ, 0, 3, 3, 0, 0, 0, 0);
        send_item(MODE_PIX, 0, 0, 0, 32'h8000_0000, 0, 0, 0);
        send_item(MODE_PIX, 0, 255, 255, 32'h7FFF_FFFF, 0, 0, 0);
        send_item(MODE_PIX, 0, 5, 7, 32'h0001_0000, 0, 0, 0);
        send_item(MODE_SPARE, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                  16'hFFFF);
        send_item(MODE_READ, 0, 0, 0, 0, 0, 0, 0);
        send_item(MODE_READ, 0, 255, 255, 0, 0, 0, 0);
        send_item(MODE_READ, 0, 5, 7, 0, 0, 0, 0);
        send_item(MODE_READ, 0, 100, 100, 0, 0, 0, 0);
        send_item(MODE_READ, 0, 0, 0, 0, 0, 0, 0);
        wait_idle();

        // Each phase picks new sizes and bounds, then runs mixed random traffic.
        // Sizes stay small so rescans remain cheap, except for the thin strips.
        for (int p = 0; p < 9; p++) begin
            case (p)
                0: set_regs(16, 16, 256, 0, 0);
                // Zero registers saturate to the smallest sizes, and flat data gives
                // a zero span.
                1: set_regs(0, 0, 0, 0, 0);
                2: set_regs(9'h1FF, 1, 9'h1FF, 32'h8000_0000, 32'h7FFF_FFFF);
                3: set_regs(1, 256, 2, pick_bound(), pick_bound());
                default: set_regs($urandom_range(1, 16), $urandom_range(1, 16),
                                  $urandom_range(2, 256), pick_bound(), pick_bound());
            endcase
            for (int i = 0; i < 120; i++) begin
                n = $urandom_range(0, 99);
                if ($urandom_range(0, 99) < 85) begin
                    x = $urandom_range(0, sb.width - 1);
                    y = $urandom_range(0, sb.height - 1);
                end else begin
                    x = $urandom_range(0, 255);
                    y = $urandom_range(0, 255);
                end
                if (n < 40) send_item(MODE_PIX, $urandom, x, y, pick_value(),
                                      $urandom, $urandom, $urandom);
                else if (n < 85) send_item(MODE_READ, $urandom, x, y, $urandom,
                                           $urandom, $urandom, $urandom);
                else if (n < 95) send_item(MODE_MAP, $urandom, x, y, $urandom,
                                           $urandom, $urandom, $urandom);
                else send_item(MODE_SPARE, $urandom, x, y, $urandom,
                               $urandom, $urandom, $urandom);
            end
            wait_idle();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("colormap_pixel_shader_top: match");
        end else begin
            $display("colormap_pixel_shader_top: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
